[src/pip_pkg.sv]
// Shared types and constants of the point-in-polygon test core.
// Used by pip_vstore, pip_xmul and point_in_polygon_test_core.
// No dependencies.
package pip_pkg;

  // Store size and field widths.
  localparam int MaxVertices = 1024;
  localparam int IndexW      = 10;
  localparam int AddrW       = IndexW;
  localparam int CountW      = 11;
  localparam int CoordW      = 32;
  localparam int DiffW       = CoordW + 1;
  localparam int ProdW       = 2 * DiffW;
  localparam int MinVertices = 3;

  // Packing of the input tdata, lowest bits first.
  localparam int InDataW  = 80;
  localparam int IdxLsb   = 0;
  localparam int XLsb     = IdxLsb + IndexW;
  localparam int YLsb     = XLsb + CoordW;
  localparam int OutDataW = 8;

  // Item kinds carried in tuser.
  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // Write request into the vertex store.
  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  addr;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } vs_wr_t;

  // Read request into the vertex store.
  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] addr;
  } vs_rd_t;

  // Sequencer states.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LAST = 8'b0000_0010,
    S_VERT = 8'b0000_0100,
    S_D1   = 8'b0000_1000,
    S_D2   = 8'b0001_0000,
    S_M2   = 8'b0010_0000,
    S_CMP  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

endpackage

[src/pip_vstore.sv]
// Vertex store: x and y memories with one write port and one registered read port.
// Depends on pip_pkg.
module pip_vstore (
  input  logic                          clk_i,
  input  pip_pkg::vs_wr_t               wr_i,
  input  pip_pkg::vs_rd_t               rd_i,
  output logic [pip_pkg::CoordW-1:0]    rd_x_o,
  output logic [pip_pkg::CoordW-1:0]    rd_y_o
);
  import pip_pkg::*;

  logic [CoordW-1:0] mem_x [MaxVertices];
  logic [CoordW-1:0] mem_y [MaxVertices];
  logic [CoordW-1:0] rd_x_q;
  logic [CoordW-1:0] rd_y_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_x[wr_i.addr] <= wr_i.x;
      mem_y[wr_i.addr] <= wr_i.y;
    end
  end

  // Read port, data valid in the cycle after the request.
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rd_x_q <= mem_x[rd_i.addr];
      rd_y_q <= mem_y[rd_i.addr];
    end
  end

  assign rd_x_o = rd_x_q;
  assign rd_y_o = rd_y_q;

endmodule

[src/pip_xmul.sv]
// Shared exact signed multiplier with registered operands and product.
// Depends on pip_pkg.
module pip_xmul (
  input  logic                               clk_i,
  input  logic                               ld_i,
  input  logic signed [pip_pkg::DiffW-1:0]   a_i,
  input  logic signed [pip_pkg::DiffW-1:0]   b_i,
  output logic signed [pip_pkg::ProdW-1:0]   prod_o
);
  import pip_pkg::*;

  logic signed [DiffW-1:0] op_a_q;
  logic signed [DiffW-1:0] op_b_q;
  logic signed [ProdW-1:0] prod_q;

  // Operands are loaded on request; the product register follows the operand registers.
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      op_a_q <= a_i;
      op_b_q <= b_i;
    end
    prod_q <= ProdW'(op_a_q) * ProdW'(op_b_q);
  end

  assign prod_o = prod_q;

endmodule

[src/point_in_polygon_test_core.sv]
// Top level of the even-odd point-in-polygon test: sequencer, edge walk and output register.
// Depends on pip_pkg, pip_vstore and pip_xmul.
//
// Channel   Direction  Handshake                     Contents
// s_axis    in         s_axis_tvalid/s_axis_tready   load vertex or query point
// m_axis    out        m_axis_tvalid/m_axis_tready   inside bit of a query
// cfg       in         cfg_we_i                      vertex_count
//
// A load item is written straight into the store. A query item walks the n vertices in use;
// each vertex costs one store read, and each edge that crosses the line through the point also
// passes S_D1, S_D2, S_M2 and S_CMP for the shared multiplier and the compare.
// A query with fewer than three vertices answers without reading the store.
// Reset clears the sequencer, the vertex count and the output valid flag, not the store.
// The input is not ready while a query runs; a finished answer waits in the output register,
// and a second answer waits in the sequencer until that register is taken.
module point_in_polygon_test_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [9:0] vertex_index, [41:10] coord_x, [73:42] coord_y, [79:74] zero
  input  logic [pip_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] func
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] inside_res, [7:1] zero
  output logic [pip_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [pip_pkg::CountW-1:0]    cfg_wdata_i
);
  import pip_pkg::*;

  state_e state_q, state_d;

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] n_used;
  logic [AddrW-1:0]  last_q, last_d;
  logic [AddrW-1:0]  idx_q, idx_d;

  logic signed [CoordW-1:0] px_q, px_d, py_q, py_d;
  logic signed [CoordW-1:0] lx_q, lx_d, ly_q, ly_d;
  logic signed [CoordW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic lflag_q, lflag_d, cflag_q, cflag_d;
  logic inside_q, inside_d;
  logic signed [ProdW-1:0] p1_q, p1_d;

  logic out_valid_q, out_valid_d, out_bit_q, out_bit_d;

  logic signed [CoordW-1:0] in_x, in_y, rd_xs, rd_ys;
  logic [CoordW-1:0] rd_x, rd_y;
  logic              in_fire;
  logic              rd_flag;

  vs_wr_t wr;
  vs_rd_t rd;

  logic                    mul_ld;
  logic signed [DiffW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] prod;

  pip_vstore u_vstore (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .rd_i   (rd),
    .rd_x_o (rd_x),
    .rd_y_o (rd_y)
  );

  pip_xmul u_xmul (
    .clk_i  (clk_i),
    .ld_i   (mul_ld),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_x          = $signed(s_axis_tdata[XLsb +: CoordW]);
  assign in_y          = $signed(s_axis_tdata[YLsb +: CoordW]);
  assign rd_xs         = $signed(rd_x);
  assign rd_ys         = $signed(rd_y);
  assign rd_flag       = (rd_ys >= py_q);

  // Vertices in use, limited to the store size.
  assign n_used = (count_q > CountW'(MaxVertices)) ? CountW'(MaxVertices) : count_q;

  // Vertex loads go straight into the store.
  always_comb begin
    wr.we   = in_fire && (s_axis_tuser[0] == FuncLoad);
    wr.addr = s_axis_tdata[IdxLsb +: AddrW];
    wr.x    = s_axis_tdata[XLsb +: CoordW];
    wr.y    = s_axis_tdata[YLsb +: CoordW];
  end

  // Sequencer and edge walk.
  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    idx_d       = idx_q;
    px_d        = px_q;
    py_d        = py_q;
    lx_d        = lx_q;
    ly_d        = ly_q;
    lflag_d     = lflag_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cflag_d     = cflag_q;
    inside_d    = inside_q;
    p1_d        = p1_q;
    rd.re       = 1'b0;
    rd.addr     = idx_q;
    mul_ld      = 1'b0;
    mul_a       = {cy_q[CoordW-1], cy_q} - {py_q[CoordW-1], py_q};
    mul_b       = {lx_q[CoordW-1], lx_q} - {cx_q[CoordW-1], cx_q};
    out_valid_d = out_valid_q && !m_axis_tready;
    out_bit_d   = out_bit_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (s_axis_tuser[0] == FuncQuery)) begin
          px_d     = in_x;
          py_d     = in_y;
          inside_d = 1'b0;
          idx_d    = '0;
          last_d   = AddrW'(n_used - CountW'(1));
          if (n_used < CountW'(MinVertices)) begin
            state_d = S_DONE;
          end else begin
            // Fetch the last vertex, which precedes vertex zero.
            rd.re   = 1'b1;
            rd.addr = AddrW'(n_used - CountW'(1));
            state_d = S_LAST;
          end
        end
      end

      S_LAST: begin
        lx_d    = rd_xs;
        ly_d    = rd_ys;
        lflag_d = rd_flag;
        rd.re   = 1'b1;
        rd.addr = idx_q;
        state_d = S_VERT;
      end

      S_VERT: begin
        cx_d    = rd_xs;
        cy_d    = rd_ys;
        cflag_d = rd_flag;
        if (rd_flag != lflag_q) begin
          // The edge crosses the line: compare the cross products.
          state_d = S_D1;
        end else begin
          lx_d    = rd_xs;
          ly_d    = rd_ys;
          lflag_d = rd_flag;
          if (idx_q == last_q) begin
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + AddrW'(1);
            rd.re   = 1'b1;
            rd.addr = idx_q + AddrW'(1);
          end
        end
      end

      S_D1: begin
        // First product: (y - py) * (lx - x).
        mul_ld  = 1'b1;
        state_d = S_D2;
      end

      S_D2: begin
        // Second product: (x - px) * (ly - y).
        mul_ld  = 1'b1;
        mul_a   = {cx_q[CoordW-1], cx_q} - {px_q[CoordW-1], px_q};
        mul_b   = {ly_q[CoordW-1], ly_q} - {cy_q[CoordW-1], cy_q};
        state_d = S_M2;
      end

      S_M2: begin
        p1_d    = prod;
        state_d = S_CMP;
      end

      S_CMP: begin
        if ((p1_q >= prod) == cflag_q) begin
          inside_d = !inside_q;
        end
        lx_d    = cx_q;
        ly_d    = cy_q;
        lflag_d = cflag_q;
        if (idx_q == last_q) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + AddrW'(1);
          rd.re   = 1'b1;
          rd.addr = idx_q + AddrW'(1);
          state_d = S_VERT;
        end
      end

      S_DONE: begin
        // Hand the answer over once the output register is free.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_bit_d   = inside_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    last_q    <= last_d;
    idx_q     <= idx_d;
    px_q      <= px_d;
    py_q      <= py_d;
    lx_q      <= lx_d;
    ly_q      <= ly_d;
    lflag_q   <= lflag_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    cflag_q   <= cflag_d;
    inside_q  <= inside_d;
    p1_q      <= p1_d;
    out_bit_q <= out_bit_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 1){1'b0}}, out_bit_q};

endmodule
